// ===== src/rtcz_pkg.sv =====
package rtcz_pkg;

  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  // Word index of the zone offset register, taken from paddr[PaddrWidth-1].
  localparam logic RegZoneOffset = 1'b0;

  localparam logic signed [4:0] ZoneOffsetReset = -5'sd3;
  localparam logic [11:0] BaseYear = 12'd2000;
  localparam logic [11:0] WrapYear = 12'd2100;
  localparam logic signed [8:0] HoursPerDay = 9'sd24;
  localparam logic [7:0] MonthsPerYear = 8'd12;

  localparam logic [4:0] MonthLen [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    SelSec   = 3'd0,
    SelMin   = 3'd1,
    SelHour  = 3'd2,
    SelDay   = 3'd3,
    SelMonth = 3'd4,
    SelYear  = 3'd5
  } sel_e;

  typedef struct packed {
    logic [7:0] bcd_seconds;
    logic [7:0] bcd_minutes;
    logic [7:0] bcd_hours;
    logic [7:0] bcd_day;
    logic [7:0] bcd_month;
    logic [7:0] bcd_year;
    logic [2:0] operation;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  local_seconds;
    logic [5:0]  local_minutes;
    logic [4:0]  local_hour;
    logic [4:0]  local_day;
    logic [3:0]  local_month;
    logic [11:0] local_year;
    logic [11:0] chosen_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        sec;
    logic [7:0]        min;
    logic signed [8:0] hour;
    logic [7:0]        day;
    logic [7:0]        mon;
    logic [11:0]       year;
    logic [2:0]        sel;
  } dec_t;

  typedef struct packed {
    logic [7:0]        sec;
    logic [7:0]        min;
    logic [4:0]        hour;
    logic signed [8:0] day;
    logic [7:0]        mon;
    logic [11:0]       year;
    logic [4:0]        dim_cur;
    logic [7:0]        mon_prev;
    logic [11:0]       year_prev;
    logic [4:0]        dim_prev;
    logic [2:0]        sel;
  } cal_t;

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Years seen here lie between 1999 and 2165, where 2000 is the only
  // multiple of 400 and 2100 the only other multiple of 100.
  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != WrapYear);
  endfunction

  function automatic logic [4:0] days_in(input logic [7:0] m, input logic [11:0] y);
    logic [4:0] len;
    if (m < 8'd1 || m > MonthsPerYear) begin
      len = 5'd0;
    end else if (m == 8'd2 && leap_year(y)) begin
      len = 5'd29;
    end else begin
      len = MonthLen[m[3:0]];
    end
    return len;
  endfunction

endpackage

// ===== src/rtcz_req_if.sv =====
interface rtcz_req_if import rtcz_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== src/rtcz_rsp_if.sv =====
interface rtcz_rsp_if import rtcz_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== src/rtcz_decode_stage.sv =====
module rtcz_decode_stage import rtcz_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  in_item_t          item_i,
  input  logic signed [4:0] zone_i,
  output logic              valid_o,
  output dec_t              item_o
);

  logic valid_q;
  dec_t item_d;
  dec_t item_q;

  always_comb begin
    item_d.sec  = bcd_decode(item_i.bcd_seconds);
    item_d.min  = bcd_decode(item_i.bcd_minutes);
    item_d.hour = $signed({1'b0, bcd_decode(item_i.bcd_hours)}) +
                  $signed({{4{zone_i[4]}}, zone_i});
    item_d.day  = bcd_decode(item_i.bcd_day);
    item_d.mon  = bcd_decode(item_i.bcd_month);
    item_d.year = BaseYear + {4'b0, bcd_decode(item_i.bcd_year)};
    item_d.sel  = item_i.operation;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/rtcz_wrap_stage.sv =====
module rtcz_wrap_stage import rtcz_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dec_t item_i,
  output logic valid_o,
  output cal_t item_o
);

  logic              valid_q;
  cal_t              item_d;
  cal_t              item_q;
  logic signed [8:0] hour_w;
  logic signed [8:0] day_w;

  always_comb begin
    hour_w = item_i.hour;
    day_w  = $signed({1'b0, item_i.day});
    if (item_i.hour >= HoursPerDay) begin
      hour_w = item_i.hour - HoursPerDay;
      day_w  = day_w + 9'sd1;
    end else if (item_i.hour < 9'sd0) begin
      hour_w = item_i.hour + HoursPerDay;
      day_w  = day_w - 9'sd1;
    end

    item_d.sec  = item_i.sec;
    item_d.min  = item_i.min;
    item_d.hour = hour_w[4:0];
    item_d.day  = day_w;
    item_d.mon  = item_i.mon;
    item_d.year = item_i.year;
    item_d.sel  = item_i.sel;
    item_d.dim_cur = days_in(item_i.mon, item_i.year);
    if (item_i.mon <= 8'd1) begin
      item_d.mon_prev  = MonthsPerYear;
      item_d.year_prev = item_i.year - 12'd1;
    end else begin
      item_d.mon_prev  = item_i.mon - 8'd1;
      item_d.year_prev = item_i.year;
    end
    item_d.dim_prev = days_in(item_d.mon_prev, item_d.year_prev);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/rtcz_roll_stage.sv =====
module rtcz_roll_stage import rtcz_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cal_t      item_i,
  output logic      valid_o,
  output out_item_t item_o
);

  logic              valid_q;
  out_item_t         item_d;
  out_item_t         item_q;
  logic              roll_fwd;
  logic              roll_back;
  logic [4:0]        day_f;
  logic [7:0]        mon_f;
  logic [11:0]       year_f;

  assign roll_fwd  = item_i.day > $signed({4'b0, item_i.dim_cur});
  assign roll_back = item_i.day <= 9'sd0;

  always_comb begin
    day_f  = item_i.day[4:0];
    mon_f  = item_i.mon;
    year_f = item_i.year;
    if (roll_fwd) begin
      day_f = 5'd1;
      if (item_i.mon >= MonthsPerYear) begin
        mon_f  = 8'd1;
        year_f = item_i.year + 12'd1;
      end else begin
        mon_f = item_i.mon + 8'd1;
      end
    end else if (roll_back) begin
      day_f  = item_i.dim_prev;
      mon_f  = item_i.mon_prev;
      year_f = item_i.year_prev;
    end

    item_d.local_seconds = item_i.sec[5:0];
    item_d.local_minutes = item_i.min[5:0];
    item_d.local_hour    = item_i.hour;
    item_d.local_day     = day_f;
    item_d.local_month   = mon_f[3:0];
    item_d.local_year    = year_f;

    unique case (sel_e'(item_i.sel))
      SelSec:   item_d.chosen_value = {6'b0, item_d.local_seconds};
      SelMin:   item_d.chosen_value = {6'b0, item_d.local_minutes};
      SelHour:  item_d.chosen_value = {7'b0, item_d.local_hour};
      SelDay:   item_d.chosen_value = {7'b0, item_d.local_day};
      SelMonth: item_d.chosen_value = {8'b0, item_d.local_month};
      SelYear:  item_d.chosen_value = item_d.local_year;
      default:  item_d.chosen_value = 12'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  a_roll_fwd_day_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && roll_fwd |=> item_q.local_day == 5'd1)
    else $error("forward rollover did not give day one");

  a_roll_back_last_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && !roll_fwd && roll_back
      |=> item_q.local_day == $past(item_i.dim_prev))
    else $error("backward rollover did not give the previous month length");

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_q))
    else $error("output stage valid changed while stalled");

endmodule

// ===== src/rtc_bcd_timezone_date_adjust_top.sv =====
// Converts a real-time-clock reading of six BCD bytes into local calendar time.
// The req_i channel carries one reading per item together with a field
// selector; the rsp_o channel returns the six decoded local fields and the
// selected field. Both channels use a valid/ready handshake.
// The zone offset register is written through the APB port at any address
// with paddr[PaddrWidth-1] clear, and may only change while no item is in flight.
// An accepted item passes through the decode, hour wrap and date rollover
// register stages in that order and is then presented on rsp_o.
// Throughput is one item per cycle unless rsp_o stalls; the three stages
// advance together. When the receiver stalls, all stages hold their contents
// and req_i.ready drops, so nothing is lost or repeated.
// Reset clears every stage valid bit and sets the zone offset to minus three
// hours.
module rtc_bcd_timezone_date_adjust_top import rtcz_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtcz_req_if.sink              req_i,
  rtcz_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  logic signed [4:0] zone_q;
  logic              cfg_wr;
  logic              en;
  logic              s1_valid;
  dec_t              s1_item;
  logic              s2_valid;
  cal_t              s2_item;
  logic              s3_valid;
  out_item_t         s3_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PaddrWidth-1] == RegZoneOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ZoneOffsetReset;
    end else if (cfg_wr) begin
      zone_q <= $signed(pwdata[4:0]);
    end
  end

  always_comb begin
    if (paddr[PaddrWidth-1] == RegZoneOffset) begin
      prdata = {{(PdataWidth-5){zone_q[4]}}, zone_q};
    end else begin
      prdata = '0;
    end
  end

  assign en          = !s3_valid || rsp_o.ready;
  assign req_i.ready = en;

  rtcz_decode_stage u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .item_i  (req_i.item),
    .zone_i  (zone_q),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  rtcz_wrap_stage u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .valid_o (s2_valid),
    .item_o  (s2_item)
  );

  rtcz_roll_stage u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid),
    .item_i  (s2_item),
    .valid_o (s3_valid),
    .item_o  (s3_item)
  );

  assign rsp_o.valid = s3_valid;
  assign rsp_o.item  = s3_item;

  a_cfg_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> zone_q == $signed($past(pwdata[4:0])))
    else $error("zone offset write was not stored");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("item accepted while the output stage is stalled");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_valid)
    else $error("accepted item did not enter the first stage");

endmodule

// ===== tb/tb.sv =====
module tb;
  import rtcz_pkg::*;

  localparam int ReadingsPerPhase = 190;
  localparam int NumPhases = 10;
  localparam int HoldOffCycles = 300;
  localparam int StallLimit = 2000;
  localparam int IdlePercent = 19;
  localparam int NoisePercent = 20;
  localparam int TailCycles = 8;

  localparam logic signed [4:0] ZoneMin = -5'sd16;
  localparam logic signed [4:0] ZoneMax = 5'sd15;
  localparam logic [2:0] SelNoneLow = 3'd6;
  localparam logic [2:0] SelNoneHigh = 3'd7;

  localparam int DaysPerMonth [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    in_item_t  reading;
    bit        typed;
    out_item_t want;
  } table_row_t;

  typedef struct {
    bit        typed;
    out_item_t want;
  } pin_t;

  // Rows marked typed carry their local time as written here; the rest are predicted.
  // All rows run at the zone offset left by reset.
  localparam table_row_t DirRows [17] = '{
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, SelSec}, 1'b1,
      '{6'd0, 6'd0, 5'd21, 5'd31, 4'd12, 12'd1999, 12'd0}},
    '{'{8'h45, 8'h30, 8'h12, 8'h15, 8'h06, 8'h24, SelHour}, 1'b1,
      '{6'd45, 6'd30, 5'd9, 5'd15, 4'd6, 12'd2024, 12'd9}},
    '{'{8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, SelYear}, 1'b1,
      '{6'd0, 6'd0, 5'd22, 5'd31, 4'd12, 12'd1999, 12'd1999}},
    '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SelNoneHigh}, 1'b1,
      '{6'd37, 6'd37, 5'd10, 5'd1, 4'd1, 12'd2166, 12'd0}},
    '{'{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, SelMin}, 1'b1,
      '{6'd59, 6'd59, 5'd20, 5'd31, 4'd12, 12'd2099, 12'd59}},
    '{'{8'h00, 8'h00, 8'h27, 8'h28, 8'h02, 8'h00, SelDay}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h27, 8'h28, 8'h02, 8'h24, SelMonth}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h27, 8'h28, 8'h02, 8'h23, SelDay}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h27, 8'h31, 8'h12, 8'h99, SelYear}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h02, 8'h01, 8'h03, 8'h00, SelDay}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'hA0, SelDay}, 1'b0, '0},
    '{'{8'h10, 8'h20, 8'h05, 8'h05, 8'h13, 8'h50, SelMonth}, 1'b0, '0},
    '{'{8'h10, 8'h20, 8'h05, 8'h05, 8'h00, 8'h50, SelDay}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h01, 8'h00, 8'h13, 8'h50, SelDay}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h10, 8'h00, 8'h15, 8'h50, SelNoneLow}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h10, 8'h31, 8'h04, 8'h50, SelMonth}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h02, 8'h01, 8'h01, 8'h00, SelHour}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic pready;

  rtcz_req_if req_if ();
  rtcz_rsp_if rsp_if ();

  pin_t pin_q [$];
  out_item_t local_time_q [$];
  logic signed [4:0] zone_now;
  int items_sent;
  int results_seen;
  int mismatches;
  int stall_cycles;
  bit hold_req;
  bit steady;

  rtc_bcd_timezone_date_adjust_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  function automatic int bcd_value(logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int m, int y);
    int len;
    if (m < 1 || m > 12) begin
      len = 0;
    end else if (m == 2 && is_leap_year(y)) begin
      len = 29;
    end else begin
      len = DaysPerMonth[m];
    end
    return len;
  endfunction

  function automatic out_item_t calc_local_time(in_item_t r, logic signed [4:0] zone);
    int sec;
    int min;
    int hr;
    int dy;
    int mo;
    int yr;
    out_item_t o;
    sec = bcd_value(r.bcd_seconds);
    min = bcd_value(r.bcd_minutes);
    hr = bcd_value(r.bcd_hours) + int'(zone);
    dy = bcd_value(r.bcd_day);
    mo = bcd_value(r.bcd_month);
    yr = bcd_value(r.bcd_year) + 2000;
    if (hr >= 24) begin
      hr = hr - 24;
      dy = dy + 1;
    end else if (hr < 0) begin
      hr = hr + 24;
      dy = dy - 1;
    end
    if (dy > month_days(mo, yr)) begin
      dy = 1;
      mo = mo + 1;
      if (mo > 12) begin
        mo = 1;
        yr = yr + 1;
      end
    end else if (dy <= 0) begin
      mo = mo - 1;
      if (mo <= 0) begin
        mo = 12;
        yr = yr - 1;
      end
      dy = month_days(mo, yr);
    end
    o.local_seconds = sec[5:0];
    o.local_minutes = min[5:0];
    o.local_hour = hr[4:0];
    o.local_day = dy[4:0];
    o.local_month = mo[3:0];
    o.local_year = yr[11:0];
    case (r.operation)
      SelSec:   o.chosen_value = 12'(o.local_seconds);
      SelMin:   o.chosen_value = 12'(o.local_minutes);
      SelHour:  o.chosen_value = 12'(o.local_hour);
      SelDay:   o.chosen_value = 12'(o.local_day);
      SelMonth: o.chosen_value = 12'(o.local_month);
      SelYear:  o.chosen_value = o.local_year;
      default:  o.chosen_value = 12'd0;
    endcase
    return o;
  endfunction

  // Mostly plausible readings near hour and month boundaries, plus raw byte noise.
  function automatic in_item_t make_reading();
    in_item_t r;
    int y;
    int m;
    int d;
    int h;
    r.operation = 3'($urandom_range(7));
    if ($urandom_range(99) < NoisePercent) begin
      r.bcd_seconds = 8'($urandom_range(255));
      r.bcd_minutes = 8'($urandom_range(255));
      r.bcd_hours = 8'($urandom_range(255));
      r.bcd_day = 8'($urandom_range(255));
      r.bcd_month = 8'($urandom_range(255));
      r.bcd_year = 8'($urandom_range(255));
    end else begin
      y = $urandom_range(99);
      m = $urandom_range(12, 1);
      case ($urandom_range(3))
        0: d = 1;
        1: d = month_days(m, 2000 + y);
        2: d = month_days(m, 2000 + y) - 1;
        default: d = $urandom_range(28, 1);
      endcase
      case ($urandom_range(2))
        0: h = $urandom_range(3);
        1: h = $urandom_range(23, 20);
        default: h = $urandom_range(23);
      endcase
      r.bcd_seconds = to_bcd($urandom_range(59));
      r.bcd_minutes = to_bcd($urandom_range(59));
      r.bcd_hours = to_bcd(h);
      r.bcd_day = to_bcd(d);
      r.bcd_month = to_bcd(m);
      r.bcd_year = to_bcd(y);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic offer_reading(in_item_t r, bit typed, out_item_t want);
    pin_t pin;
    if (!steady) begin
      while ($urandom_range(99) < IdlePercent) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    pin.typed = typed;
    pin.want = want;
    pin_q.push_back(pin);
    req_if.valid <= 1'b1;
    req_if.item <= r;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  task automatic write_zone(logic signed [4:0] z);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegZoneOffset, {(PaddrWidth - 1){1'b0}}};
    pwdata <= {{(PdataWidth - 5){z[4]}}, z};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    zone_now = z;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin : reading_accept
    pin_t pin;
    if (rst_ni && req_if.valid && req_if.ready) begin
      pin = pin_q.pop_front();
      local_time_q.push_back(pin.typed ? pin.want : calc_local_time(req_if.item, zone_now));
    end
  end

  always @(posedge clk_i) begin : local_time_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      got = rsp_if.item;
      if (local_time_q.size() == 0) begin
        $display("%0t: expected no item, got %h", $time, got);
        mismatches++;
      end else begin
        want = local_time_q.pop_front();
        check_field("local_seconds", 12'(want.local_seconds), 12'(got.local_seconds));
        check_field("local_minutes", 12'(want.local_minutes), 12'(got.local_minutes));
        check_field("local_hour", 12'(want.local_hour), 12'(got.local_hour));
        check_field("local_day", 12'(want.local_day), 12'(got.local_day));
        check_field("local_month", 12'(want.local_month), 12'(got.local_month));
        check_field("local_year", want.local_year, got.local_year);
        check_field("chosen_value", want.chosen_value, got.chosen_value);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic signed [4:0] zone_plan [NumPhases];
    int p;
    int i;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    zone_now = ZoneOffsetReset;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    stall_cycles = 0;
    hold_req = 1'b0;
    steady = 1'b0;
    zone_plan[0] = ZoneMin;
    zone_plan[1] = ZoneMax;
    zone_plan[2] = -5'sd12;
    zone_plan[3] = 5'sd14;
    zone_plan[4] = 5'sd0;
    for (p = 5; p < NumPhases; p++) begin
      zone_plan[p] = 5'($urandom_range(31));
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirRows[k]) begin
      offer_reading(DirRows[k].reading, DirRows[k].typed, DirRows[k].want);
    end
    wait_drained();
    for (p = 0; p < NumPhases; p++) begin
      write_zone(zone_plan[p]);
      steady = (p == 3);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      for (i = 0; i < ReadingsPerPhase; i++) begin
        offer_reading(make_reading(), 1'b0, '0);
      end
      wait_drained();
      steady = 1'b0;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && local_time_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rtcz_pkg.sv
src/rtcz_req_if.sv
src/rtcz_rsp_if.sv
src/rtcz_decode_stage.sv
src/rtcz_wrap_stage.sv
src/rtcz_roll_stage.sv
src/rtc_bcd_timezone_date_adjust_top.sv
tb/tb.sv
